@@ rtl/background_match_frame_decay_assert.svh @@
// Assertion macros shared by the background-match frame decay RTL.
// Plain text macros only; no other file or package is needed here.
`ifndef BACKGROUND_MATCH_FRAME_DECAY_ASSERT_SVH
`define BACKGROUND_MATCH_FRAME_DECAY_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define BMFD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define BMFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/bmfd_pkg.sv @@
// Package for the background-match frame decay block: widths, register
// indexes, the pipeline enable struct and per-channel helper functions.
package bmfd_pkg;

	localparam int unsigned FRAME_PIXELS_DEF = 65536;
	localparam int IDX_W = 16;
	localparam int CH_W = 8;
	localparam int RGB_W = 3 * CH_W;
	localparam logic [CH_W-1:0] THRESHOLD_RST = 8'd16;
	localparam logic [CH_W-1:0] DECAY_RST = 8'd0;

	typedef enum logic [0:0] {
		REG_MATCH_THRESHOLD = 1'b0,
		REG_DECAY_AMOUNT    = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic ld1;
		logic ld2;
	} stage_en_t;

	function automatic int pos_width(int unsigned n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

	// True when b - t <= c <= b + t, evaluated without wrap.
	function automatic logic chan_match(logic [CH_W-1:0] c, logic [CH_W-1:0] b,
			logic [CH_W-1:0] t);
		logic [CH_W:0] c_hi;
		logic [CH_W:0] b_hi;
		c_hi = {1'b0, c} + {1'b0, t};
		b_hi = {1'b0, b} + {1'b0, t};
		return (c_hi >= {1'b0, b}) && ({1'b0, c} <= b_hi);
	endfunction

	// A zero channel stays zero; anything else drops by the decay, mod 256.
	function automatic logic [CH_W-1:0] chan_decay(logic [CH_W-1:0] p,
			logic [CH_W-1:0] d);
		return (p == '0) ? '0 : p - d;
	endfunction

endpackage

@@ rtl/bmfd_pos_reduce.sv @@
// Two-stage reduction of the pixel index modulo the frame size.
// Depends on bmfd_pkg for widths and the stage enable struct.
module bmfd_pos_reduce import bmfd_pkg::*; #(
	parameter int unsigned FRAME_PIXELS = FRAME_PIXELS_DEF,
	localparam int POS_W = pos_width(FRAME_PIXELS)
) (
	input  logic             clk,
	input  stage_en_t        en,
	input  logic [IDX_W-1:0] idx,
	output logic [POS_W-1:0] pos
);

	logic [IDX_W-1:0] idx_s1;
	logic [IDX_W-1:0] idx_s2;

	always_ff @(posedge clk) begin
		if (en.ld1) begin
			idx_s1 <= idx;
		end
		if (en.ld2) begin
			idx_s2 <= idx_s1;
		end
	end

	generate
		if (FRAME_PIXELS > (2 ** IDX_W)) begin : g_wide
			// Every index already lies inside the frame.
			assign pos = POS_W'(idx_s2);
		end else if ((FRAME_PIXELS & (FRAME_PIXELS - 1)) == 0) begin : g_pow2
			assign pos = POS_W'(idx_s2) & POS_W'(FRAME_PIXELS - 1);
		end else begin : g_recip
			// The quotient is the top bits of idx times ceil(2^32 / N), which is
			// exact for every 16-bit index when N is below 2^16.
			localparam logic [31:0] RECIP =
				32'(((64'd1 << 32) + 64'(FRAME_PIXELS) - 64'd1) / 64'(FRAME_PIXELS));
			localparam logic [IDX_W-1:0] DIVISOR = IDX_W'(FRAME_PIXELS);

			logic [IDX_W+31:0] prod_s1;
			logic [IDX_W-1:0]  qn_s2;

			always_ff @(posedge clk) begin
				if (en.ld1) begin
					prod_s1 <= idx * RECIP;
				end
				if (en.ld2) begin
					qn_s2 <= prod_s1[IDX_W+31:32] * DIVISOR;
				end
			end

			assign pos = POS_W'(idx_s2 - qn_s2);
		end
	endgenerate

endmodule

@@ rtl/background_match_frame_decay.sv @@
// Background-match frame decay: an accepted pixel passes stages 1, 2, 3 and the output
// register to res_valid. Throughput is one pixel per cycle unless res_ready is low, set
// by one read and one write per clock on each frame memory. Reset clears the pipeline
// valids, the background-valid flag and the registers (threshold 16, decay 0); the frame
// memories are not cleared. Depends on bmfd_pkg, bmfd_pos_reduce and the assert header.
`include "background_match_frame_decay_assert.svh"

module background_match_frame_decay import bmfd_pkg::*; #(
	parameter int unsigned FRAME_PIXELS = FRAME_PIXELS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	// Configuration write channel.
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [0:0]       cfg_index,
	input  logic [CH_W-1:0]  cfg_data,
	// Pixel input channel.
	input  logic             pix_valid,
	output logic             pix_ready,
	input  logic             kind,
	input  logic [IDX_W-1:0] pixel_index,
	input  logic [CH_W-1:0]  red_in,
	input  logic [CH_W-1:0]  green_in,
	input  logic [CH_W-1:0]  blue_in,
	// Result channel.
	output logic             res_valid,
	input  logic             res_ready,
	output logic [CH_W-1:0]  red_out,
	output logic [CH_W-1:0]  green_out,
	output logic [CH_W-1:0]  blue_out,
	output logic             replaced
);

	localparam int POS_W = pos_width(FRAME_PIXELS);

	// Pipeline overview.
	// Stage 1 and 2 hold the transaction while the index is reduced to a frame
	// position. On the move into stage 3 both memories are read at that
	// position. Stage 3 compares against the background, builds the result and
	// writes the memories as the transaction leaves for the output register.
	// Since the only writer is stage 3, the one overlap to cover is a transaction
	// entering stage 3 while the one ahead of it writes the same position; the
	// written data is captured then and used in place of the stale read.

	// Configuration registers and the background-valid flag.
	logic [CH_W-1:0] thr_q;
	logic [CH_W-1:0] decay_q;
	logic            bg_valid_q;

	// Pipeline registers.
	logic             valid_s1, valid_s2, valid_s3;
	logic             kind_s1, kind_s2, kind_s3;
	logic [RGB_W-1:0] rgb_s1, rgb_s2, rgb_s3;
	logic [POS_W-1:0] pos_s3;
	logic [RGB_W-1:0] bg_rd_s3, pv_rd_s3;
	logic [RGB_W-1:0] fwd_bg_s3, fwd_pv_s3;
	logic             fwd_bg_hit_s3, fwd_pv_hit_s3;

	// Output register.
	logic             res_valid_q;
	logic [CH_W-1:0]  red_q, green_q, blue_q;
	logic             replaced_q;

	// Frame memories.
	logic [RGB_W-1:0] bg_mem [FRAME_PIXELS];
	logic [RGB_W-1:0] pv_mem [FRAME_PIXELS];

	// Flow control. The output register frees stage 3, and each stage loads when
	// it is empty or the stage after it loads.
	logic      adv3, mv3, ld3;
	stage_en_t en;

	assign adv3   = !res_valid_q || res_ready;
	assign mv3    = valid_s3 && adv3;
	assign ld3    = !valid_s3 || adv3;
	assign en.ld2 = !valid_s2 || ld3;
	assign en.ld1 = !valid_s1 || en.ld2;

	assign pix_ready = en.ld1;
	assign cfg_ready = 1'b1;

	// Index reduction to the frame position that stage 2 presents to the memories.
	logic [POS_W-1:0] pos_rd;

	bmfd_pos_reduce #(
		.FRAME_PIXELS(FRAME_PIXELS)
	) u_pos_reduce (
		.clk (clk),
		.en  (en),
		.idx (pixel_index),
		.pos (pos_rd)
	);

	// Stage 3 datapath: forwarded or read background and previous output.
	logic [RGB_W-1:0] bg_cur, pv_cur;
	logic [RGB_W-1:0] res_rgb;
	logic             all_match;
	logic             hit;
	logic             pv_we, bg_we;

	assign bg_cur = fwd_bg_hit_s3 ? fwd_bg_s3 : bg_rd_s3;
	assign pv_cur = fwd_pv_hit_s3 ? fwd_pv_s3 : pv_rd_s3;

	always_comb begin
		all_match = 1'b1;
		for (int k = 0; k < 3; k++) begin
			all_match = all_match &&
				chan_match(rgb_s3[k*CH_W +: CH_W], bg_cur[k*CH_W +: CH_W], thr_q);
		end
		hit = !kind_s3 && bg_valid_q && all_match;
		for (int k = 0; k < 3; k++) begin
			res_rgb[k*CH_W +: CH_W] = hit ?
				chan_decay(pv_cur[k*CH_W +: CH_W], decay_q) : rgb_s3[k*CH_W +: CH_W];
		end
	end

	// A capture writes both stores; a process transaction writes the previous
	// output only once a background exists. Capture results equal the input, so
	// the previous-output write data is the result in every case.
	assign pv_we = mv3 && (kind_s3 || bg_valid_q);
	assign bg_we = mv3 && kind_s3;

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q         <= THRESHOLD_RST;
			decay_q       <= DECAY_RST;
			bg_valid_q    <= 1'b0;
			valid_s1      <= 1'b0;
			valid_s2      <= 1'b0;
			valid_s3      <= 1'b0;
			res_valid_q   <= 1'b0;
			fwd_bg_hit_s3 <= 1'b0;
			fwd_pv_hit_s3 <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_MATCH_THRESHOLD: thr_q <= cfg_data;
					REG_DECAY_AMOUNT:    decay_q <= cfg_data;
				endcase
			end
			if (bg_we) begin
				bg_valid_q <= 1'b1;
			end
			if (en.ld1) begin
				valid_s1 <= pix_valid;
			end
			if (en.ld2) begin
				valid_s2 <= valid_s1;
			end
			if (ld3) begin
				valid_s3      <= valid_s2;
				fwd_bg_hit_s3 <= valid_s2 && bg_we && (pos_s3 == pos_rd);
				fwd_pv_hit_s3 <= valid_s2 && pv_we && (pos_s3 == pos_rd);
			end
			if (adv3) begin
				res_valid_q <= valid_s3;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (en.ld1) begin
			kind_s1 <= kind;
			rgb_s1  <= {blue_in, green_in, red_in};
		end
		if (en.ld2) begin
			kind_s2 <= kind_s1;
			rgb_s2  <= rgb_s1;
		end
		if (ld3) begin
			kind_s3   <= kind_s2;
			rgb_s3    <= rgb_s2;
			pos_s3    <= pos_rd;
			fwd_bg_s3 <= rgb_s3;
			fwd_pv_s3 <= res_rgb;
		end
		if (adv3) begin
			red_q      <= res_rgb[0*CH_W +: CH_W];
			green_q    <= res_rgb[1*CH_W +: CH_W];
			blue_q     <= res_rgb[2*CH_W +: CH_W];
			replaced_q <= hit;
		end
	end

	// Background memory: read on entry to stage 3, written by a departing capture.
	always_ff @(posedge clk) begin
		if (ld3) begin
			bg_rd_s3 <= bg_mem[pos_rd];
		end
		if (bg_we) begin
			bg_mem[pos_s3] <= rgb_s3;
		end
	end

	// Previous-output memory: same read point, written with every stored result.
	always_ff @(posedge clk) begin
		if (ld3) begin
			pv_rd_s3 <= pv_mem[pos_rd];
		end
		if (pv_we) begin
			pv_mem[pos_s3] <= res_rgb;
		end
	end

	assign res_valid = res_valid_q;
	assign red_out   = red_q;
	assign green_out = green_q;
	assign blue_out  = blue_q;
	assign replaced  = replaced_q;

	// A replaced pixel can only come after some capture has set the flag.
	`BMFD_ASSERT_NOW(a_replaced_needs_bg, clk, arst_n, res_valid_q && replaced_q, bg_valid_q, "replaced result without a captured background")

	// Forwarded data only ever belongs to a live transaction in stage 3.
	`BMFD_ASSERT_NOW(a_fwd_live, clk, arst_n, fwd_pv_hit_s3, valid_s3, "forward hit with empty stage 3")

	// A background forward always comes with a previous-output forward.
	`BMFD_ASSERT_NOW(a_fwd_pair, clk, arst_n, fwd_bg_hit_s3, fwd_pv_hit_s3, "background forward without previous-output forward")

	// A capture leaving stage 3 marks the background as present.
	`BMFD_ASSERT_NEXT(a_capture_sets_bg, clk, arst_n, bg_we, bg_valid_q, "capture did not set background-valid")

endmodule

@@ test/background_match_frame_decay_test.sv @@
// Self-checking testbench for background_match_frame_decay: directed and random pixel
// transactions, with a built-in predictor of the background match and frame decay.
// Depends on bmfd_pkg and the background_match_frame_decay RTL only.
module background_match_frame_decay_test import bmfd_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	// Input kinds carried on the one-bit kind port.
	localparam logic KIND_PROCESS = 1'b0;
	localparam logic KIND_CAPTURE = 1'b1;

	// Settling margin after the last expected result, to cover anything still in flight.
	localparam int SETTLE_CYCLES = 8;
	// Length of the long receiver hold-off used to back the block up.
	localparam int HOLD_OFF_CYCLES = 80;
	// Random transactions per register setting, swept over 3 idle patterns x 6 settings.
	localparam int PHASE_ITEMS = 75;

	typedef struct packed {
		logic             kind;
		logic [IDX_W-1:0] index;
		logic [CH_W-1:0]  red;
		logic [CH_W-1:0]  green;
		logic [CH_W-1:0]  blue;
	} pixel_item_t;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic            replaced;
	} pixel_result_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [0:0]       cfg_index = REG_MATCH_THRESHOLD;
	logic [CH_W-1:0]  cfg_data = '0;
	logic             pix_valid = 1'b0;
	logic             pix_ready;
	logic             kind = KIND_PROCESS;
	logic [IDX_W-1:0] pixel_index = '0;
	logic [CH_W-1:0]  red_in = '0;
	logic [CH_W-1:0]  green_in = '0;
	logic [CH_W-1:0]  blue_in = '0;
	logic             res_valid;
	logic             res_ready = 1'b0;
	logic [CH_W-1:0]  red_out;
	logic [CH_W-1:0]  green_out;
	logic [CH_W-1:0]  blue_out;
	logic             replaced;

	background_match_frame_decay #(
		.FRAME_PIXELS(FRAME_PIXELS_DEF)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.pix_valid  (pix_valid),
		.pix_ready  (pix_ready),
		.kind       (kind),
		.pixel_index(pixel_index),
		.red_in     (red_in),
		.green_in   (green_in),
		.blue_in    (blue_in),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.red_out    (red_out),
		.green_out  (green_out),
		.blue_out   (blue_out),
		.replaced   (replaced)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Predictor state. The frame stores are sparse: a position only exists once it
	// has been captured, which also tells the stimulus where a process transaction
	// may safely land. Channels are packed red in the low byte.
	logic [RGB_W-1:0] background_mem [int];
	logic [RGB_W-1:0] previous_mem [int];
	logic             background_seen = 1'b0;
	logic [CH_W-1:0]  match_thr = THRESHOLD_RST;
	logic [CH_W-1:0]  decay_amt = DECAY_RST;
	int               captured_pos[$];

	// Results still owed by the block, oldest first.
	pixel_result_t    expected_pixels[$];
	int               err_count = 0;

	// Idle percentages for the sender and the receiver, changed per phase.
	int               send_idle_pct = 0;
	int               recv_idle_pct = 0;

	// A test asks for a long hold-off by bumping the request count; the receiver
	// process serves each request once and counts the stall cycles itself.
	int               hold_off_requests = 0;
	int               hold_off_served = 0;
	int               hold_cycles_left = 0;

	// A few fixed positions, frame corners among them, so that runs of transactions
	// keep hitting the same entry back to back and stress read-after-write in the
	// pipeline.
	int               hot_pos[6] = '{0, 1, 2, 16'h7FFF, 16'h8000, 16'hFFFF};

	function automatic logic near_background(logic [CH_W-1:0] c, logic [CH_W-1:0] b);
		return (int'(c) + int'(match_thr) >= int'(b)) && (int'(c) <= int'(b) + int'(match_thr));
	endfunction

	function automatic logic [CH_W-1:0] fade_channel(logic [CH_W-1:0] p);
		logic [CH_W-1:0] faded;
		faded = p - decay_amt;
		return (p == '0) ? '0 : faded;
	endfunction

	// Works out the result of one accepted pixel and updates the frame stores the
	// same way the block does.
	function automatic pixel_result_t predict_pixel(pixel_item_t it);
		pixel_result_t    res;
		logic [RGB_W-1:0] bg;
		logic [RGB_W-1:0] pv;
		int               pos;
		pos = int'(it.index) % FRAME_PIXELS_DEF;
		res = '{red: it.red, green: it.green, blue: it.blue, replaced: 1'b0};
		if (it.kind == KIND_CAPTURE) begin
			if (!background_mem.exists(pos))
				captured_pos.push_back(pos);
			background_mem[pos] = {it.blue, it.green, it.red};
			previous_mem[pos] = {it.blue, it.green, it.red};
			background_seen = 1'b1;
		end else if (background_seen) begin
			bg = background_mem[pos];
			pv = previous_mem[pos];
			if (near_background(it.red, bg[7:0]) && near_background(it.green, bg[15:8]) &&
					near_background(it.blue, bg[23:16])) begin
				res.red = fade_channel(pv[7:0]);
				res.green = fade_channel(pv[15:8]);
				res.blue = fade_channel(pv[23:16]);
				res.replaced = 1'b1;
			end
			previous_mem[pos] = {res.blue, res.green, res.red};
		end
		return res;
	endfunction

	// A channel value a little inside or outside the match window around b.
	function automatic logic [CH_W-1:0] shade_near(logic [CH_W-1:0] b);
		int lo;
		int hi;
		lo = int'(b) - int'(match_thr) - 2;
		hi = int'(b) + int'(match_thr) + 2;
		if (lo < 0)
			lo = 0;
		if (hi > 255)
			hi = 255;
		return CH_W'($urandom_range(hi, lo));
	endfunction

	// Mostly well-formed traffic: processes land on captured positions, with
	// channels near the background so that matches, near misses and decay chains
	// all show up. The rest is fresh captures and fully random channel values.
	function automatic pixel_item_t random_pixel();
		pixel_item_t      it;
		int               pos;
		logic [RGB_W-1:0] bg;
		it.kind = KIND_PROCESS;
		it.red = CH_W'($urandom_range(255));
		it.green = CH_W'($urandom_range(255));
		it.blue = CH_W'($urandom_range(255));
		if ($urandom_range(99) < 8) begin
			it.red = $urandom_range(1) ? 8'hFF : 8'h00;
			it.blue = $urandom_range(1) ? 8'hFF : 8'h00;
		end
		if (captured_pos.size() == 0 || $urandom_range(99) < 12) begin
			it.kind = KIND_CAPTURE;
			pos = ($urandom_range(99) < 50) ? hot_pos[$urandom_range(5)] :
				int'($urandom_range(16'hFFFF));
		end else begin
			pos = ($urandom_range(99) < 70) ? hot_pos[$urandom_range(5)] :
				captured_pos[$urandom_range(captured_pos.size() - 1)];
			if (!background_mem.exists(pos)) begin
				it.kind = KIND_CAPTURE;
			end else if ($urandom_range(99) < 75) begin
				bg = background_mem[pos];
				if ($urandom_range(99) < 85)
					it.red = shade_near(bg[7:0]);
				if ($urandom_range(99) < 85)
					it.green = shade_near(bg[15:8]);
				if ($urandom_range(99) < 85)
					it.blue = shade_near(bg[23:16]);
			end
		end
		it.index = IDX_W'(pos);
		return it;
	endfunction

	// Offers one pixel transaction, idling first at the current rate, and records
	// its expected result once the block takes it. Valid stays high into the next
	// call when no idle cycle follows.
	task automatic send_pixel(input pixel_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			pix_valid <= 1'b0;
			@(posedge clk);
		end
		pix_valid <= 1'b1;
		kind <= it.kind;
		pixel_index <= it.index;
		red_in <= it.red;
		green_in <= it.green;
		blue_in <= it.blue;
		do
			@(posedge clk);
		while (!pix_ready);
		expected_pixels.push_back(predict_pixel(it));
	endtask

	// Waits until every expected result has come back, then lets the pipeline settle.
	task automatic wait_idle();
		pix_valid <= 1'b0;
		while (expected_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Offers one register write and returns once it is taken. Valid stays high so
	// that a following write can go out in the next cycle.
	task automatic write_reg(input cfg_reg_t idx, input logic [CH_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		if (idx == REG_MATCH_THRESHOLD)
			match_thr = value;
		else
			decay_amt = value;
	endtask

	// Registers are only ever written with the block drained.
	task automatic set_config(input logic [CH_W-1:0] thr, input logic [CH_W-1:0] decay);
		wait_idle();
		write_reg(REG_MATCH_THRESHOLD, thr);
		write_reg(REG_DECAY_AMOUNT, decay);
		cfg_valid <= 1'b0;
	endtask

	// Before any capture a process transaction passes straight through and leaves
	// the stores alone, at any position.
	task automatic test_passthrough_before_capture();
		send_pixel(pixel_item_t'{KIND_PROCESS, 16'h0000, 8'h00, 8'h00, 8'h00});
		send_pixel(pixel_item_t'{KIND_PROCESS, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF});
		send_pixel(pixel_item_t'{KIND_PROCESS, 16'h5555, 8'hAA, 8'h55, 8'h0F});
	endtask

	// Window edges at the reset threshold, decay of zero channels, wrap of the
	// decay, and both register extremes.
	task automatic test_match_and_decay();
		send_pixel(pixel_item_t'{KIND_CAPTURE, 16'h1234, 8'd100, 8'd0, 8'd255});
		// Exactly on the window edges: plus, zero plus, minus the threshold.
		send_pixel(pixel_item_t'{KIND_PROCESS, 16'h1234, 8'd116, 8'd16, 8'd239});
		send_pixel(pixel_item_t'{KIND_PROCESS, 16'h1234, 8'd84, 8'd0, 8'd255});
		// One step outside the window on each channel in turn.
		send_pixel(pixel_item_t'{KIND_PROCESS, 16'h1234, 8'd117, 8'd0, 8'd255});
		send_pixel(pixel_item_t'{KIND_PROCESS, 16'h1234, 8'd100, 8'd0, 8'd238});
		send_pixel(pixel_item_t'{KIND_PROCESS, 16'h1234, 8'd100, 8'd17, 8'd255});
		// A match now returns the last passed-through pixel.
		send_pixel(pixel_item_t'{KIND_PROCESS, 16'h1234, 8'd100, 8'd0, 8'd255});
		send_pixel(pixel_item_t'{KIND_CAPTURE, 16'hFFFF, 8'd0, 8'd255, 8'd1});
		send_pixel(pixel_item_t'{KIND_PROCESS, 16'hFFFF, 8'd0, 8'd255, 8'd1});

		// Back-to-back decays of the same position.
		set_config(8'd16, 8'd1);
		send_pixel(pixel_item_t'{KIND_PROCESS, 16'h1234, 8'd100, 8'd0, 8'd255});
		send_pixel(pixel_item_t'{KIND_PROCESS, 16'h1234, 8'd101, 8'd1, 8'd250});

		// Zero threshold needs an exact match; a decay of 255 wraps.
		set_config(8'd0, 8'd255);
		send_pixel(pixel_item_t'{KIND_PROCESS, 16'hFFFF, 8'd0, 8'd255, 8'd1});
		send_pixel(pixel_item_t'{KIND_PROCESS, 16'hFFFF, 8'd1, 8'd255, 8'd1});
		send_pixel(pixel_item_t'{KIND_PROCESS, 16'hFFFF, 8'd0, 8'd255, 8'd1});

		// Full threshold matches anything.
		set_config(8'd255, 8'd200);
		send_pixel(pixel_item_t'{KIND_CAPTURE, 16'h0000, 8'd0, 8'd0, 8'd0});
		send_pixel(pixel_item_t'{KIND_PROCESS, 16'h0000, 8'd255, 8'd255, 8'd255});
		send_pixel(pixel_item_t'{KIND_CAPTURE, 16'hAAAA, 8'd255, 8'd128, 8'd7});
		send_pixel(pixel_item_t'{KIND_PROCESS, 16'hAAAA, 8'd0, 8'd0, 8'd0});
		wait_idle();
	endtask

	// Random traffic under three idle patterns, each swept over several register
	// settings including the extremes.
	task automatic test_random_stream();
		for (int mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin
					send_idle_pct = 35;
					recv_idle_pct = 67;
				end
				1: begin
					send_idle_pct = 67;
					recv_idle_pct = 35;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int setting = 0; setting < 6; setting++) begin
				case (setting)
					0: set_config(8'd0, 8'd0);
					1: set_config(8'd255, 8'd255);
					2: set_config(THRESHOLD_RST, 8'd1);
					3: set_config(8'd0, 8'd255);
					4: set_config(8'd255, 8'd0);
					default: set_config(CH_W'($urandom_range(40)), CH_W'($urandom_range(255)));
				endcase
				repeat (PHASE_ITEMS) send_pixel(random_pixel());
			end
		end
		wait_idle();
	endtask

	// The receiver stops for a long stretch while the sender keeps offering
	// transactions, so the pipeline fills and input ready has to drop.
	task automatic test_output_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_config(8'd20, 8'd3);
		hold_off_requests++;
		repeat (48) send_pixel(random_pixel());
		wait_idle();
	endtask

	// Receiver: checks each result transaction against the oldest expectation and
	// then picks ready for the next cycle.
	always @(posedge clk) begin : result_check
		pixel_result_t want;
		if (arst_n && res_valid && res_ready) begin
			if (expected_pixels.size() == 0) begin
				$error("result with nothing expected: red %0d green %0d blue %0d replaced %0b",
					red_out, green_out, blue_out, replaced);
				err_count++;
			end else begin
				want = expected_pixels.pop_front();
				if (red_out !== want.red) begin
					$error("red_out: expected %0d, actual %0d", want.red, red_out);
					err_count++;
				end
				if (green_out !== want.green) begin
					$error("green_out: expected %0d, actual %0d", want.green, green_out);
					err_count++;
				end
				if (blue_out !== want.blue) begin
					$error("blue_out: expected %0d, actual %0d", want.blue, blue_out);
					err_count++;
				end
				if (replaced !== want.replaced) begin
					$error("replaced: expected %0b, actual %0b", want.replaced, replaced);
					err_count++;
				end
			end
		end
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else if (hold_cycles_left > 0) begin
			hold_cycles_left = hold_cycles_left - 1;
			res_ready <= 1'b0;
		end else if (hold_off_served != hold_off_requests) begin
			hold_off_served = hold_off_served + 1;
			hold_cycles_left = HOLD_OFF_CYCLES - 1;
			res_ready <= 1'b0;
		end else begin
			res_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_passthrough_before_capture();
		test_match_and_decay();
		test_random_stream();
		test_output_backpressure();
		wait_idle();
		if (err_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Far beyond the slowest correct run.
	initial begin
		#1000000;
		$display("status: fail");
		$finish;
	end

endmodule
